FILE: hw/rtl/ipsvm_pkg.sv
`default_nettype none
package ipsvm_pkg;

  localparam int DUTY_FRAC_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF     = 16;

  localparam int CORDIC_STAGES = 24;
  localparam int XW            = 44;  // CORDIC vector width
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [31:0] CORDIC_GAIN   = 32'd2608131496;
  localparam logic [31:0] INV_SQRT3     = 32'd2479700525;
  localparam logic [16:0] MAX_MOD_RESET = 17'd37837;
  localparam logic signed [23:0] Q16_ONE = 24'sd65536;

  typedef struct packed {
    logic               bus_zero;
    logic signed [15:0] vd;
    logic signed [15:0] vq;
    logic [15:0]        bus;
    logic [31:0]        sum;
    logic [1:0]         quad;
    logic signed [31:0] z;
  } ipsvm_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZERO, ST_SQRT, ST_LIM, ST_NUM, ST_DIV, ST_PRE, ST_CORDIC,
    ST_GAIN_X, ST_GAIN_Y, ST_GAIN_B, ST_SCALE_S, ST_ROUND_S, ST_SEXT, ST_DUTY
  } back_state_t;

  typedef enum logic [2:0] {
    SEXT_1 = 3'd1, SEXT_2 = 3'd2, SEXT_3 = 3'd3,
    SEXT_4 = 3'd4, SEXT_5 = 3'd5, SEXT_6 = 3'd6
  } sext_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [31:0] v);
    logic signed [17:0] r;
    if (v > 32'sd131071) r = 18'sd131071;
    else if (v < -32'sd131072) r = -18'sd131072;
    else r = v[17:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ipsvm_front.sv
`default_nettype none
module ipsvm_front #(
  parameter int ANGLE_BITS = ipsvm_pkg::ANGLE_BITS_DEF
) (
  input  wire logic signed [15:0] volt_d,
  input  wire logic signed [15:0] volt_q,
  input  wire logic [15:0]        bus_volt,
  input  wire logic [15:0]        rotor_angle,
  output ipsvm_pkg::ipsvm_item_t  item_o
);
  import ipsvm_pkg::*;

  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  logic signed [31:0] sq_d, sq_q;
  logic [31:0]        ang_ext, a32, ru, quad_sum;
  logic [1:0]         quad;

  assign sq_d = 32'(volt_d) * 32'(volt_d);
  assign sq_q = 32'(volt_q) * 32'(volt_q);

  // Reduce the angle to the nearest quarter turn; the residue is signed.
  assign ang_ext  = {16'd0, rotor_angle};
  assign a32      = (ang_ext & ANG_MASK) << (32 - ANGLE_BITS);
  assign quad_sum = a32 + 32'h2000_0000;
  assign quad     = quad_sum[31:30];
  assign ru       = a32 - {quad, 30'd0};

  always_comb begin
    item_o.bus_zero = (bus_volt == 16'd0);
    item_o.vd       = volt_d;
    item_o.vq       = volt_q;
    item_o.bus      = bus_volt;
    item_o.sum      = $unsigned(sq_d) + $unsigned(sq_q);
    item_o.quad     = quad;
    item_o.z        = $signed(ru);
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ipsvm_queue.sv
`default_nettype none
module ipsvm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  ipsvm_pkg::ipsvm_item_t item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output ipsvm_pkg::ipsvm_item_t item_o,
  output logic                   empty_o
);
  import ipsvm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  ipsvm_item_t      entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full_o  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_r == '0);
  assign item_o  = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop_i)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push_i && !pop_i)      count_r <= count_r + 1'b1;
      else if (pop_i && !push_i) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) entry_r[wr_ptr_r] <= item_i;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && !pop_i |=> !empty_o) else $error("pushed item not visible");

endmodule
`default_nettype wire

FILE: hw/rtl/ipsvm_back.sv
`default_nettype none
module ipsvm_back #(
  parameter int DUTY_FRAC_BITS = ipsvm_pkg::DUTY_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [16:0]       max_mod_i,
  input  ipsvm_pkg::ipsvm_item_t item_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [17:0]     out_duty_a,
  output logic signed [17:0]     out_duty_b,
  output logic signed [17:0]     out_duty_c,
  output logic                   out_duties_valid,
  output logic [15:0]            out_volt_magnitude,
  output logic signed [17:0]     out_ref_alpha,
  output logic signed [17:0]     out_ref_beta
);
  import ipsvm_pkg::*;

  localparam int DUTY_SHL  = (DUTY_FRAC_BITS >= 17) ? DUTY_FRAC_BITS - 17 : 0;
  localparam int DUTY_SHR  = (DUTY_FRAC_BITS < 17) ? 17 - DUTY_FRAC_BITS : 0;
  localparam int DUTY_HALF = (1 << DUTY_SHR) >> 1;

  back_state_t state_r, state_nxt;
  ipsvm_item_t item_r;
  logic [5:0]  cnt_r;
  logic        out_free;

  // square root
  logic [63:0] sq_rad_r;
  logic [33:0] sq_rem_r, sq_rem_sh, sq_trial;
  logic [31:0] sq_root_r;
  // limit and division
  logic        limited_r;
  logic [15:0] mag_r;
  logic [31:0] den_r;
  logic [32:0] dv_rem_d_r, dv_rem_q_r, dv_sh_d, dv_sh_q;
  logic [47:0] dv_n_d_r, dv_n_q_r;
  logic [33:0] lim_prod;
  logic [16:0] factor;
  logic [15:0] abs_d, abs_q;
  logic [31:0] num_d, num_q;
  // rotation
  logic signed [XW-1:0] x_r, y_r, pd, pq, pd_mag, pq_mag, dx, dy;
  logic signed [31:0]   z_r, atan_s;
  logic [XW-1:0]        g_mag;
  logic [27:0]          g_clamp;
  logic [59:0]          prod_r;
  logic                 neg_r;
  logic signed [17:0]   al_r, be_r, s_r;
  logic [49:0]          sp_r;
  logic [17:0]          abs_be;
  logic [50:0]          s_sum;
  // modulation
  sext_t                sext_r, sext_c;
  logic signed [23:0]   al_e, s_e, u_c, v_c, u_r, v_r, h_r;
  logic signed [23:0]   ta, tb, tc, t_mid, t_hi, p_w, q_w;
  logic                 duty_ok;

  function automatic logic signed [17:0] gain_round(input logic [59:0] p,
                                                    input logic neg);
    logic [59:0]        t;
    logic signed [31:0] r;
    t = p + (60'd1 << 39);
    r = $signed({12'd0, t[59:40]});
    if (neg) r = -r;
    return sat18(r);
  endfunction

  function automatic logic signed [17:0] duty_out(input logic signed [23:0] t);
    logic signed [31:0] w;
    logic [31:0]        mag;
    w = 32'(t);
    if (DUTY_FRAC_BITS >= 17) begin
      w = w <<< DUTY_SHL;
    end else begin
      mag = $unsigned(w[31] ? -w : w);
      mag = (mag + 32'(DUTY_HALF)) >> DUTY_SHR;
      w = t[23] ? -$signed(mag) : $signed(mag);
    end
    return sat18(w);
  endfunction

  function automatic logic in_unit(input logic signed [23:0] t);
    return (t >= 24'sd0) && (t <= 24'sd131072);
  endfunction

  assign out_free = !out_valid || out_ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pop_o     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          state_nxt = item_i.bus_zero ? ST_ZERO : ST_SQRT;
        end
      end
      ST_ZERO:    if (out_free) state_nxt = ST_IDLE;
      ST_SQRT:    if (cnt_r == 6'd31) state_nxt = ST_LIM;
      ST_LIM:     state_nxt = ST_NUM;
      ST_NUM:     state_nxt = ST_DIV;
      ST_DIV:     if (cnt_r == 6'd47) state_nxt = ST_PRE;
      ST_PRE:     state_nxt = ST_CORDIC;
      ST_CORDIC:  if (cnt_r == 6'(CORDIC_STAGES - 1)) state_nxt = ST_GAIN_X;
      ST_GAIN_X:  state_nxt = ST_GAIN_Y;
      ST_GAIN_Y:  state_nxt = ST_GAIN_B;
      ST_GAIN_B:  state_nxt = ST_SCALE_S;
      ST_SCALE_S: state_nxt = ST_ROUND_S;
      ST_ROUND_S: state_nxt = ST_SEXT;
      ST_SEXT:    state_nxt = ST_DUTY;
      ST_DUTY:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath steps
  always_comb begin
    sq_rem_sh = {sq_rem_r[31:0], sq_rad_r[63:62]};
    sq_trial  = {sq_root_r, 2'b01};
    lim_prod  = ({1'b0, max_mod_i} + 18'd1) * item_r.bus;
    factor    = limited_r ? max_mod_i : 17'd1;
    abs_d     = item_r.vd[15] ? 16'(-item_r.vd) : item_r.vd;
    abs_q     = item_r.vq[15] ? 16'(-item_r.vq) : item_r.vq;
    num_d     = abs_d * factor;
    num_q     = abs_q * factor;
    dv_sh_d   = {dv_rem_d_r[31:0], dv_n_d_r[47]};
    dv_sh_q   = {dv_rem_q_r[31:0], dv_n_q_r[47]};
    pd_mag    = $signed({{(XW-40){1'b0}}, dv_n_d_r[31:0], 8'd0});
    pq_mag    = $signed({{(XW-40){1'b0}}, dv_n_q_r[31:0], 8'd0});
    pd        = item_r.vd[15] ? -pd_mag : pd_mag;
    pq        = item_r.vq[15] ? -pq_mag : pq_mag;
    dx        = y_r >>> cnt_r[4:0];
    dy        = x_r >>> cnt_r[4:0];
    atan_s    = $signed({2'b00, atan_turn(cnt_r[4:0])});
    g_mag     = (state_r == ST_GAIN_X) ? $unsigned(x_r[XW-1] ? -x_r : x_r)
                                       : $unsigned(y_r[XW-1] ? -y_r : y_r);
    // Beyond 2^27 the scaled result saturates anyway.
    g_clamp   = (g_mag >= (XW'(1) << 27)) ? 28'h800_0000 : g_mag[27:0];
    abs_be    = be_r[17] ? 18'(-be_r) : be_r;
    s_sum     = {1'b0, sp_r} + (51'd1 << 31);
  end

  // Sextant and the two active vector times
  always_comb begin
    al_e = 24'(al_r);
    s_e  = 24'(s_r);
    if (be_r >= 0) begin
      if (al_r >= 0) sext_c = (s_e > al_e) ? SEXT_2 : SEXT_1;
      else           sext_c = (-s_e > al_e) ? SEXT_3 : SEXT_2;
    end else begin
      if (al_r >= 0) sext_c = (-s_e > al_e) ? SEXT_5 : SEXT_6;
      else           sext_c = (s_e > al_e) ? SEXT_4 : SEXT_5;
    end
    unique case (sext_c)
      SEXT_1:  begin u_c = al_e - s_e;  v_c = s_e <<< 1;    end
      SEXT_2:  begin u_c = al_e + s_e;  v_c = s_e - al_e;   end
      SEXT_3:  begin u_c = s_e <<< 1;   v_c = -al_e - s_e;  end
      SEXT_4:  begin u_c = s_e - al_e;  v_c = -(s_e <<< 1); end
      SEXT_5:  begin u_c = -al_e - s_e; v_c = al_e - s_e;   end
      default: begin u_c = -(s_e <<< 1); v_c = al_e + s_e;  end
    endcase
  end

  // Duty times, held as twice the duty; the lowest phase starts at h.
  always_comb begin
    unique case (sext_r)
      SEXT_1, SEXT_4, SEXT_5: p_w = (sext_r == SEXT_4) ? v_r : u_r;
      default:                p_w = (sext_r == SEXT_3) ? u_r : v_r;
    endcase
    q_w   = (p_w == u_r && sext_r != SEXT_2 && sext_r != SEXT_6) ? v_r : u_r;
    if (sext_r == SEXT_4) q_w = u_r;
    if (sext_r == SEXT_3) q_w = v_r;
    t_mid = h_r + (p_w <<< 1);
    t_hi  = t_mid + (q_w <<< 1);
    unique case (sext_r)
      SEXT_1:  begin ta = h_r;   tb = t_mid; tc = t_hi;  end
      SEXT_2:  begin tb = h_r;   ta = t_mid; tc = t_hi;  end
      SEXT_3:  begin tb = h_r;   tc = t_mid; ta = t_hi;  end
      SEXT_4:  begin tc = h_r;   tb = t_mid; ta = t_hi;  end
      SEXT_5:  begin tc = h_r;   ta = t_mid; tb = t_hi;  end
      default: begin ta = h_r;   tc = t_mid; tb = t_hi;  end
    endcase
    duty_ok = in_unit(ta) && in_unit(tb) && in_unit(tc);
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_r + 6'd1;
    unique case (state_r)
      ST_IDLE: begin
        item_r    <= item_i;
        sq_rad_r  <= {item_i.sum, 32'd0};
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        cnt_r     <= '0;
      end
      ST_SQRT: begin
        sq_rad_r <= {sq_rad_r[61:0], 2'b00};
        if (sq_rem_sh >= sq_trial) begin
          sq_rem_r  <= sq_rem_sh - sq_trial;
          sq_root_r <= {sq_root_r[30:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_rem_sh;
          sq_root_r <= {sq_root_r[30:0], 1'b0};
        end
      end
      ST_LIM: begin
        limited_r <= ({2'b00, sq_root_r} >= lim_prod);
        mag_r     <= sq_root_r[31:16];
      end
      ST_NUM: begin
        dv_n_d_r   <= {num_d, 16'd0};
        dv_n_q_r   <= {num_q, 16'd0};
        dv_rem_d_r <= '0;
        dv_rem_q_r <= '0;
        den_r      <= limited_r ? sq_root_r : {16'd0, item_r.bus};
        cnt_r      <= '0;
      end
      ST_DIV: begin
        if (dv_sh_d >= {1'b0, den_r}) begin
          dv_rem_d_r <= dv_sh_d - {1'b0, den_r};
          dv_n_d_r   <= {dv_n_d_r[46:0], 1'b1};
        end else begin
          dv_rem_d_r <= dv_sh_d;
          dv_n_d_r   <= {dv_n_d_r[46:0], 1'b0};
        end
        if (dv_sh_q >= {1'b0, den_r}) begin
          dv_rem_q_r <= dv_sh_q - {1'b0, den_r};
          dv_n_q_r   <= {dv_n_q_r[46:0], 1'b1};
        end else begin
          dv_rem_q_r <= dv_sh_q;
          dv_n_q_r   <= {dv_n_q_r[46:0], 1'b0};
        end
      end
      ST_PRE: begin
        case (item_r.quad)
          2'd1:    begin x_r <= -pq; y_r <= pd;  end
          2'd2:    begin x_r <= -pd; y_r <= -pq; end
          2'd3:    begin x_r <= pq;  y_r <= -pd; end
          default: begin x_r <= pd;  y_r <= pq;  end
        endcase
        z_r   <= item_r.z;
        cnt_r <= '0;
      end
      ST_CORDIC: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_s;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_s;
        end
      end
      ST_GAIN_X: begin
        prod_r <= g_clamp * CORDIC_GAIN;
        neg_r  <= x_r[XW-1];
      end
      ST_GAIN_Y: begin
        al_r   <= gain_round(prod_r, neg_r);
        prod_r <= g_clamp * CORDIC_GAIN;
        neg_r  <= y_r[XW-1];
      end
      ST_GAIN_B:  be_r <= gain_round(prod_r, neg_r);
      ST_SCALE_S: sp_r <= abs_be * INV_SQRT3;
      ST_ROUND_S: s_r  <= be_r[17] ? -$signed(s_sum[49:32]) : $signed(s_sum[49:32]);
      ST_SEXT: begin
        sext_r <= sext_c;
        u_r    <= u_c;
        v_r    <= v_c;
        h_r    <= Q16_ONE - u_c - v_c;
      end
      default: ;
    endcase
  end

  // Result register; the sequencer moves on to the next item once it is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((state_r == ST_ZERO || state_r == ST_DUTY) && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ZERO && out_free) begin
      out_duty_a         <= '0;
      out_duty_b         <= '0;
      out_duty_c         <= '0;
      out_duties_valid   <= 1'b0;
      out_volt_magnitude <= '0;
      out_ref_alpha      <= '0;
      out_ref_beta       <= '0;
    end else if (state_r == ST_DUTY && out_free) begin
      out_duty_a         <= duty_out(ta);
      out_duty_b         <= duty_out(tb);
      out_duty_c         <= duty_out(tc);
      out_duties_valid   <= duty_ok;
      out_volt_magnitude <= mag_r;
      out_ref_alpha      <= al_r;
      out_ref_beta       <= be_r;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> state_r != ST_IDLE) else $error("sequencer stayed idle after pop");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUTY && out_valid && !out_ready) |=> state_r == ST_DUTY)
    else $error("result dropped while receiver stalled");
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ZERO && out_free) |=> out_valid && !out_duties_valid)
    else $error("zero bus item not flagged invalid");

endmodule
`default_nettype wire

FILE: hw/rtl/inverse_park_svm_duty.sv
// Inverse Park rotation and centre-aligned space-vector duty generator.
// Input channel (in_valid/in_ready): d/q voltage command, bus voltage and
// rotor angle. Result channel (out_valid/out_ready): three phase duties,
// a valid flag, the unlimited voltage magnitude and the rotated alpha/beta.
// cfg_we/cfg_wdata write the modulation limit; write it only while idle.
// A front stage classifies each item and places it in a two-entry queue;
// a sequencer works through one item at a time: after the pop come square
// root, limit, a two-lane divider, CORDIC rotation, then gain and duty
// math. It pops no new item until the last result is in the output register.
// Items with zero bus voltage skip the arithmetic and leave duties invalid.
// The sustained item rate is set by the shared divider and square-root
// iterations.
// While the receiver stalls the result waits in the output register, the
// sequencer finishes the next item and holds it, and the queue keeps
// accepting until it is full.
// Reset empties the queue, drops any result and sets the limit to 37837.
`default_nettype none
module inverse_park_svm_duty #(
  parameter int DUTY_FRAC_BITS = ipsvm_pkg::DUTY_FRAC_BITS_DEF,
  parameter int ANGLE_BITS     = ipsvm_pkg::ANGLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_volt_d,
  input  wire logic signed [15:0] in_volt_q,
  input  wire logic [15:0]        in_bus_volt,
  input  wire logic [15:0]        in_rotor_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      out_duty_a,
  output logic signed [17:0]      out_duty_b,
  output logic signed [17:0]      out_duty_c,
  output logic                    out_duties_valid,
  output logic [15:0]             out_volt_magnitude,
  output logic signed [17:0]      out_ref_alpha,
  output logic signed [17:0]      out_ref_beta
);
  import ipsvm_pkg::*;

  logic [16:0] max_mod_r;
  ipsvm_item_t front_item, head_item;
  logic        q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n)      max_mod_r <= MAX_MOD_RESET;
    else if (cfg_we) max_mod_r <= cfg_wdata;
  end

  assign in_ready = !q_full;

  ipsvm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .volt_d      (in_volt_d),
    .volt_q      (in_volt_q),
    .bus_volt    (in_bus_volt),
    .rotor_angle (in_rotor_angle),
    .item_o      (front_item)
  );

  ipsvm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_valid && !q_full),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .empty_o (q_empty)
  );

  ipsvm_back #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .max_mod_i          (max_mod_r),
    .item_i             (head_item),
    .empty_i            (q_empty),
    .pop_o              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_duty_a         (out_duty_a),
    .out_duty_b         (out_duty_b),
    .out_duty_c         (out_duty_c),
    .out_duties_valid   (out_duties_valid),
    .out_volt_magnitude (out_volt_magnitude),
    .out_ref_alpha      (out_ref_alpha),
    .out_ref_beta       (out_ref_beta)
  );

endmodule
`default_nettype wire
